/* rtl/core/vfc_pkg.sv */
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types and constants of the voxel face culling block: grid geometry,
// face codes, command and response items, and the store write request.
// ----------------------------------------------------------------------------
package vfc_pkg;

	localparam int CHUNK_EDGE = 32;
	localparam int COORD_W    = $clog2(CHUNK_EDGE);
	localparam int EXT_W      = COORD_W + 1;
	localparam int ROW_AW     = 2 * COORD_W;
	localparam int CELL_AW    = 3 * COORD_W;
	localparam int ROWS       = CHUNK_EDGE * CHUNK_EDGE;
	localparam int CELLS      = ROWS * CHUNK_EDGE;
	localparam int CHAN_W     = 8;
	localparam int COLOR_W    = 3 * CHAN_W;
	localparam int FACE_W     = 3;
	localparam int NUM_FACES  = 6;

	localparam logic [EXT_W-1:0] EXT_MAX   = EXT_W'(CHUNK_EDGE);
	localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(32);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [FACE_W-1:0] FACE_PZ = 3'd0;
	localparam logic [FACE_W-1:0] FACE_NZ = 3'd1;
	localparam logic [FACE_W-1:0] FACE_NX = 3'd2;
	localparam logic [FACE_W-1:0] FACE_PX = 3'd3;
	localparam logic [FACE_W-1:0] FACE_PY = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NY = 3'd5;

	typedef struct packed {
		logic               op;
		logic [4:0]         vx;
		logic [4:0]         vy;
		logic [4:0]         vz;
		logic               present;
		logic [7:0]         red_in;
		logic [7:0]         green_in;
		logic [7:0]         blue_in;
	} cmd_t;

	typedef struct packed {
		logic [4:0]         fx;
		logic [4:0]         fy;
		logic [4:0]         fz;
		logic [2:0]         face;
		logic [7:0]         red_out;
		logic [7:0]         green_out;
		logic [7:0]         blue_out;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic               wr_en;
		logic               clr_en;
		logic [ROW_AW-1:0]  row;
		logic [COORD_W-1:0] bit_sel;
		logic               present;
		logic [COLOR_W-1:0] color;
	} vfc_wr_t;

endpackage

/* rtl/core/voxel_face_culling.sv */
// ----------------------------------------------------------------------------
// voxel_face_culling
// Voxel grid with visible-face extraction for a 32x32x32 chunk.
//
// Command channel: an item is taken on a clock edge with start high and busy
// low. A write item stores occupancy and color in that same cycle and leaves
// busy low, so writes stream one per cycle. A query item holds busy for five
// occupancy reads (own row for +z/-z, then the -x, +x, +y, -y rows) and one
// settle cycle, then emits its open faces one per cycle, in +z,-z,-x,+x,+y,-y
// order, with last on the final record. The first record follows the read
// phases and the first emit state, as rsp is registered; the last one shows in
// the same cycle that busy falls. The single occupancy read port is why the
// rows are read one after another. A query outside the extent never raises
// busy; one with no open face emits no record.
// Response: rsp is valid for exactly one cycle with rsp_valid high; the
// receiver cannot stall it.
// Configuration: cfg_data sets the extent when cfg_valid is high; cfg_ready
// is always high. Write it only while busy is low and no query is pending.
// Reset: extent returns to 32 and a clearing pass zeroes occupancy one row a
// cycle, with busy high. Colors are not cleared.
// ----------------------------------------------------------------------------
module voxel_face_culling import vfc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmd_t             cmd,
	output logic             rsp_valid,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [EXT_W-1:0] cfg_data
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	localparam logic [2:0] PH_SELF = 3'd0;
	localparam logic [2:0] PH_XM   = 3'd1;
	localparam logic [2:0] PH_XP   = 3'd2;
	localparam logic [2:0] PH_YP   = 3'd3;
	localparam logic [2:0] PH_YM   = 3'd4;
	localparam logic [2:0] PH_LAST = 3'd5;

	logic [1:0]            state_q;
	logic [ROW_AW-1:0]     clr_cnt_q;
	logic [EXT_W-1:0]      extent_q;
	logic [EXT_W-1:0]      ext_eff;
	cmd_t                  item_q;
	logic [2:0]            phase_q;
	logic [NUM_FACES-1:0]  open_q;
	logic                  active_q;
	logic [COLOR_W-1:0]    color_q;

	vfc_wr_t               wr;
	logic [ROW_AW-1:0]     rd_row;
	logic [CHUNK_EDGE-1:0] row_data;
	logic [COLOR_W-1:0]    color_data;

	logic                  accept;
	logic                  in_ext;
	logic [COORD_W-1:0]    xm, xp, ym, yp, zm, zp;
	logic                  x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
	logic [NUM_FACES-1:0]  pend;
	logic [NUM_FACES-1:0]  rem;
	logic [FACE_W-1:0]     pick;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_comb begin
		if (extent_q == '0) begin
			ext_eff = EXT_W'(1);
		end else if (extent_q > EXT_MAX) begin
			ext_eff = EXT_MAX;
		end else begin
			ext_eff = extent_q;
		end
	end

	assign in_ext = ({1'b0, cmd.vx} < ext_eff) && ({1'b0, cmd.vy} < ext_eff)
		&& ({1'b0, cmd.vz} < ext_eff);

	// neighbor coordinates wrap; the edge flags gate the wrapped reads
	assign xm   = item_q.vx - COORD_W'(1);
	assign xp   = item_q.vx + COORD_W'(1);
	assign ym   = item_q.vy - COORD_W'(1);
	assign yp   = item_q.vy + COORD_W'(1);
	assign zm   = item_q.vz - COORD_W'(1);
	assign zp   = item_q.vz + COORD_W'(1);
	assign x_lo = (item_q.vx == '0);
	assign y_lo = (item_q.vy == '0);
	assign z_lo = (item_q.vz == '0);
	assign x_hi = (({1'b0, item_q.vx} + EXT_W'(1)) >= ext_eff);
	assign y_hi = (({1'b0, item_q.vy} + EXT_W'(1)) >= ext_eff);
	assign z_hi = (({1'b0, item_q.vz} + EXT_W'(1)) >= ext_eff);

	always_comb begin
		wr.clr_en  = (state_q == ST_CLEAR);
		wr.wr_en   = accept && (cmd.op == OP_WRITE);
		wr.row     = (state_q == ST_CLEAR) ? clr_cnt_q : {cmd.vx, cmd.vy};
		wr.bit_sel = cmd.vz;
		wr.present = cmd.present;
		wr.color   = {cmd.red_in, cmd.green_in, cmd.blue_in};
	end

	always_comb begin
		case (phase_q)
			PH_SELF: rd_row = {item_q.vx, item_q.vy};
			PH_XM:   rd_row = {xm, item_q.vy};
			PH_XP:   rd_row = {xp, item_q.vy};
			PH_YP:   rd_row = {item_q.vx, yp};
			PH_YM:   rd_row = {item_q.vx, ym};
			default: rd_row = {item_q.vx, item_q.vy};
		endcase
	end

	vfc_store u_store (
		.clk        (clk),
		.wr         (wr),
		.rd_row     (rd_row),
		.rd_cell    ({item_q.vx, item_q.vy, item_q.vz}),
		.row_data   (row_data),
		.color_data (color_data)
	);

	// lowest pending face goes out first
	always_comb begin
		pend = active_q ? open_q : '0;
		pick = FACE_NY;
		for (int i = NUM_FACES - 1; i >= 0; i--) begin
			if (pend[i]) begin
				pick = FACE_W'(i);
			end
		end
		rem = pend & ~(NUM_FACES'(1) << pick);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extent_q <= EXT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			extent_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			phase_q   <= PH_SELF;
			rsp_valid <= 1'b0;
		end else begin
			rsp_valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + ROW_AW'(1);
					if (clr_cnt_q == ROW_AW'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (cmd.op == OP_QUERY) && in_ext) begin
						state_q <= ST_READ;
						phase_q <= PH_SELF;
					end
				end
				ST_READ: begin
					phase_q <= phase_q + 3'd1;
					if (phase_q == PH_LAST) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (pend == '0) begin
						state_q <= ST_IDLE;
					end else begin
						rsp_valid <= 1'b1;
						if (rem == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item latch, read capture and response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd;
		end
		if (state_q == ST_READ) begin
			case (phase_q)
				PH_XM: begin
					active_q  <= row_data[item_q.vz];
					open_q[0] <= z_hi || !row_data[zp];
					open_q[1] <= z_lo || !row_data[zm];
					color_q   <= color_data;
				end
				PH_XP:   open_q[2] <= x_lo || !row_data[item_q.vz];
				PH_YP:   open_q[3] <= x_hi || !row_data[item_q.vz];
				PH_YM:   open_q[4] <= y_hi || !row_data[item_q.vz];
				PH_LAST: open_q[5] <= y_lo || !row_data[item_q.vz];
				default: ;
			endcase
		end
		if (state_q == ST_EMIT) begin
			open_q        <= rem;
			rsp.fx        <= item_q.vx;
			rsp.fy        <= item_q.vy;
			rsp.fz        <= item_q.vz;
			rsp.face      <= pick;
			rsp.red_out   <= color_q[COLOR_W-1 -: CHAN_W];
			rsp.green_out <= color_q[CHAN_W +: CHAN_W];
			rsp.blue_out  <= color_q[0 +: CHAN_W];
			rsp.last      <= (rem == '0);
		end
	end

endmodule

/* rtl/core/vfc_store.sv */
// ----------------------------------------------------------------------------
// vfc_store
// Voxel storage: occupancy as rows of one bit per z, indexed by {x, y}, and
// a color memory indexed by {x, y, z}. Both reads are registered.
// ----------------------------------------------------------------------------
module vfc_store import vfc_pkg::*; (
	input  logic                  clk,
	input  vfc_wr_t               wr,
	input  logic [ROW_AW-1:0]     rd_row,
	input  logic [CELL_AW-1:0]    rd_cell,
	output logic [CHUNK_EDGE-1:0] row_data,
	output logic [COLOR_W-1:0]    color_data
);

	logic [CHUNK_EDGE-1:0] occ_mem   [ROWS];
	logic [COLOR_W-1:0]    color_mem [CELLS];

	always_ff @(posedge clk) begin
		if (wr.clr_en) begin
			occ_mem[wr.row] <= '0;
		end else if (wr.wr_en) begin
			occ_mem[wr.row][wr.bit_sel] <= wr.present;
		end
		row_data <= occ_mem[rd_row];
	end

	always_ff @(posedge clk) begin
		if (wr.wr_en) begin
			color_mem[{wr.row, wr.bit_sel}] <= wr.color;
		end
		color_data <= color_mem[rd_cell];
	end

endmodule

/* dv/vfc_checker.sv */
// ----------------------------------------------------------------------------
// vfc_checker
// Watches the command, configuration and face record channels of the voxel
// face culling block. Keeps its own copy of the occupancy grid, the voxel
// colors and the extent, works out the face records of every accepted query
// and compares each record the block emits, field by field, with the oldest
// one still due. Hands the failure count and the number of records still due
// to the testbench top.
// ----------------------------------------------------------------------------
module vfc_checker import vfc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  cmd_t             cmd,
	input  logic             rsp_valid,
	input  rsp_t             rsp,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [EXT_W-1:0] cfg_data,
	output int               errors,
	output int               pending
);

	bit                 solid [CELLS];
	logic [COLOR_W-1:0] shade [CELLS];
	logic [EXT_W-1:0]   extent = EXT_RESET;
	rsp_t               faces_due_q[$];
	int                 err_cnt = 0;

	function automatic int cell_of(int x, int y, int z);
		return (x * CHUNK_EDGE + y) * CHUNK_EDGE + z;
	endfunction

	// clamp the register into 1..CHUNK_EDGE
	function automatic int live_extent();
		if (extent == '0)
			return 1;
		if (extent > EXT_MAX)
			return CHUNK_EDGE;
		return int'(extent);
	endfunction

	function automatic void store_voxel(input cmd_t c);
		int idx;
		idx = cell_of(int'(c.vx), int'(c.vy), int'(c.vz));
		solid[idx] = c.present;
		shade[idx] = {c.red_in, c.green_in, c.blue_in};
	endfunction

	function automatic void predict_faces(input cmd_t c);
		int                e, x, y, z, nx, ny, nz, dx, dy, dz, idx;
		logic [FACE_W-1:0] code;
		rsp_t              rec, held;
		bit                have;
		e = live_extent();
		x = int'(c.vx);
		y = int'(c.vy);
		z = int'(c.vz);
		have = 0;
		if (x >= e || y >= e || z >= e)
			return;
		idx = cell_of(x, y, z);
		if (!solid[idx])
			return;
		for (int f = 0; f < NUM_FACES; f++) begin
			dx = 0;
			dy = 0;
			dz = 0;
			case (f)
				0: begin code = FACE_PZ; dz = 1; end
				1: begin code = FACE_NZ; dz = -1; end
				2: begin code = FACE_NX; dx = -1; end
				3: begin code = FACE_PX; dx = 1; end
				4: begin code = FACE_PY; dy = 1; end
				default: begin code = FACE_NY; dy = -1; end
			endcase
			nx = x + dx;
			ny = y + dy;
			nz = z + dz;
			if (nx < 0 || nx >= e || ny < 0 || ny >= e || nz < 0 || nz >= e ||
					!solid[cell_of(nx, ny, nz)]) begin
				rec.fx        = c.vx;
				rec.fy        = c.vy;
				rec.fz        = c.vz;
				rec.face      = code;
				{rec.red_out, rec.green_out, rec.blue_out} = shade[idx];
				rec.last      = 1'b0;
				// push the previous record; only the final one gets last
				if (have)
					faces_due_q.push_back(held);
				held = rec;
				have = 1;
			end
		end
		if (have) begin
			held.last = 1'b1;
			faces_due_q.push_back(held);
		end
	endfunction

	function automatic void check_face(input rsp_t got);
		rsp_t want;
		if (faces_due_q.size() == 0) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("vfc_checker: unexpected face record %0d,%0d,%0d face %0d",
					got.fx, got.fy, got.fz, got.face);
			return;
		end
		want = faces_due_q.pop_front();
		if (got.fx !== want.fx || got.fy !== want.fy || got.fz !== want.fz ||
				got.face !== want.face || got.red_out !== want.red_out ||
				got.green_out !== want.green_out || got.blue_out !== want.blue_out ||
				got.last !== want.last) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("vfc_checker: face record mismatch, expected %0d,%0d,%0d face %0d",
					want.fx, want.fy, want.fz, want.face,
					" rgb %02h%02h%02h last %0b,", want.red_out, want.green_out,
					want.blue_out, want.last,
					" got %0d,%0d,%0d face %0d", got.fx, got.fy, got.fz, got.face,
					" rgb %02h%02h%02h last %0b", got.red_out, got.green_out,
					got.blue_out, got.last);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid)
				check_face(rsp);
			if (cfg_valid && cfg_ready)
				extent = cfg_data;
			if (start && !busy) begin
				if (cmd.op == OP_WRITE)
					store_voxel(cmd);
				else
					predict_faces(cmd);
			end
			errors  <= err_cnt;
			pending <= faces_due_q.size();
		end
	end

endmodule

/* dv/tb_voxel_face_culling.sv */
// ----------------------------------------------------------------------------
// tb_voxel_face_culling
// Drives voxel writes and face queries into the voxel face culling block:
// a directed opening (grid corners, an enclosed voxel, queries outside the
// extent), then phases of random items clustered in a small box so that
// neighbors are often occupied, each phase under its own extent setting.
// The checker beside the block predicts and compares; this top gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_voxel_face_culling;
	import vfc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 22;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	cmd_t             cmd;
	logic             rsp_valid;
	rsp_t             rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [EXT_W-1:0] cfg_data;
	int               fail_count;
	int               faces_due;
	int               cycle_cnt = 0;
	bit               steady;

	voxel_face_culling uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	vfc_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.errors    (fail_count),
		.pending   (faces_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_voxel_face_culling: FAIL");
			$finish;
		end
	end

	function automatic cmd_t make_cmd(input logic op, input logic [4:0] x, input logic [4:0] y,
			input logic [4:0] z, input logic p, input logic [23:0] rgb);
		cmd_t c;
		c.op      = op;
		c.vx      = x;
		c.vy      = y;
		c.vz      = z;
		c.present = p;
		{c.red_in, c.green_in, c.blue_in} = rgb;
		return c;
	endfunction

	function automatic logic [EXT_W-1:0] extent_for_phase(input int p);
		case (p)
			0: return 6'd1;
			1: return 6'd0;
			2: return 6'd63;
			3: return 6'd2;
			4: return 6'd31;
			5: return 6'd3;
			6: return 6'd40;
			7: return 6'd17;
			8: return 6'd33;
			default: return 6'd32;
		endcase
	endfunction

	// mostly inside the box at base, some anywhere, some on the extent edge
	function automatic logic [4:0] pick_coord(input int base, input int eff);
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			return 5'(base + $urandom_range(0, 2));
		if (roll < 9)
			return 5'($urandom_range(0, 31));
		return 5'(eff - $urandom_range(0, 1));
	endfunction

	// hold start until the block takes the item
	task automatic issue_item(input cmd_t c);
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_gap();
		int          len;
		logic [63:0] noise;
		if (steady)
			return;
		len   = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
		noise = {$urandom, $urandom};
		if (len > 0) begin
			start <= 1'b0;
			cmd   <= noise[$bits(cmd_t)-1:0];
			repeat (len) @(posedge clk);
		end
	endtask

	task automatic send(input cmd_t c);
		issue_item(c);
		idle_gap();
	endtask

	// drain every due record, then let a query with no open face finish
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (faces_due != 0 || busy);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_extent(input logic [EXT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int                eff;
		int                bx, by, bz;
		logic [EXT_W-1:0]  ext;
		cmd_t              c;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		cmd       <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		steady     = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// corners, empty query, enclosed voxel
		send(make_cmd(OP_QUERY, 5'd0, 5'd0, 5'd0, 1'b0, 24'h000000));
		send(make_cmd(OP_WRITE, 5'd31, 5'd31, 5'd31, 1'b1, 24'hFFFFFF));
		send(make_cmd(OP_QUERY, 5'd31, 5'd31, 5'd31, 1'b0, 24'h000000));
		send(make_cmd(OP_WRITE, 5'd0, 5'd0, 5'd0, 1'b1, 24'h000000));
		send(make_cmd(OP_QUERY, 5'd0, 5'd0, 5'd0, 1'b1, 24'hFFFFFF));
		send(make_cmd(OP_WRITE, 5'd5, 5'd5, 5'd5, 1'b1, 24'(($urandom))));
		send(make_cmd(OP_WRITE, 5'd5, 5'd5, 5'd6, 1'b1, 24'(($urandom))));
		send(make_cmd(OP_WRITE, 5'd5, 5'd5, 5'd4, 1'b1, 24'(($urandom))));
		send(make_cmd(OP_WRITE, 5'd4, 5'd5, 5'd5, 1'b1, 24'(($urandom))));
		send(make_cmd(OP_WRITE, 5'd6, 5'd5, 5'd5, 1'b1, 24'(($urandom))));
		send(make_cmd(OP_WRITE, 5'd5, 5'd6, 5'd5, 1'b1, 24'(($urandom))));
		send(make_cmd(OP_WRITE, 5'd5, 5'd4, 5'd5, 1'b1, 24'(($urandom))));
		send(make_cmd(OP_QUERY, 5'd5, 5'd5, 5'd5, 1'b0, 24'h000000));
		send(make_cmd(OP_QUERY, 5'd5, 5'd5, 5'd6, 1'b0, 24'h000000));
		send(make_cmd(OP_WRITE, 5'd5, 5'd5, 5'd6, 1'b0, 24'(($urandom))));
		send(make_cmd(OP_QUERY, 5'd5, 5'd5, 5'd5, 1'b0, 24'h000000));
		// shrink the extent below the enclosed voxel
		settle();
		write_extent(6'd4);
		send(make_cmd(OP_QUERY, 5'd5, 5'd5, 5'd5, 1'b0, 24'h000000));
		send(make_cmd(OP_QUERY, 5'd31, 5'd31, 5'd31, 1'b0, 24'h000000));
		send(make_cmd(OP_QUERY, 5'd3, 5'd3, 5'd3, 1'b0, 24'h000000));

		for (int p = 0; p < PHASES; p++) begin
			settle();
			ext = extent_for_phase(p);
			write_extent(ext);
			eff = (ext == '0) ? 1 : (ext > EXT_MAX) ? CHUNK_EDGE : int'(ext);
			bx  = $urandom_range(0, (eff > 3) ? eff - 3 : 0);
			by  = $urandom_range(0, (eff > 3) ? eff - 3 : 0);
			bz  = $urandom_range(0, (eff > 3) ? eff - 3 : 0);
			steady = ($urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS) begin
				c = make_cmd(($urandom_range(0, 99) < 45) ? OP_QUERY : OP_WRITE,
					pick_coord(bx, eff), pick_coord(by, eff), pick_coord(bz, eff),
					($urandom_range(0, 4) != 0), 24'($urandom));
				send(c);
			end
		end
		steady = 0;

		settle();
		if (fail_count == 0 && faces_due == 0)
			$display("tb_voxel_face_culling: PASS");
		else
			$display("tb_voxel_face_culling: FAIL");
		$finish;
	end

endmodule
